// File: src/gmlc_pkg.sv
`timescale 1ns / 1ps
package gmlc_pkg;

   localparam int PIXEL_W        = 8;
   localparam int MEAN_W         = 16;
   localparam int INV_W          = 16;
   localparam int LOGNORM_W      = 16;
   localparam int LABEL_W        = 8;
   localparam int COUNT_W        = 3;
   localparam int INDEX_W        = 3;
   localparam int WORD_W         = 56;
   localparam int NUM_CLASS_REGS = 7;

   // d = pixel*256 - mean, signed Q8.8
   localparam int DIFF_W    = MEAN_W + 2;
   // |d| never exceeds 65535
   localparam int ABS_W     = MEAN_W;
   localparam int SQ_W      = 2 * ABS_W;
   localparam int PEN_W     = SQ_W + INV_W;
   // lognorm Q8.8 aligned to the Q.28 penalty
   localparam int LOG_SHIFT = 20;
   localparam int SCORE_W   = PEN_W + 2;

   localparam logic [INDEX_W-1:0] REG_COUNT  = 3'd0;
   localparam logic [INDEX_W-1:0] REG_CLASS0 = 3'd1;

   typedef struct packed {
      logic        [LABEL_W-1:0]   label;
      logic signed [LOGNORM_W-1:0] lognorm;
      logic        [INV_W-1:0]     inv2var;
      logic        [MEAN_W-1:0]    mean;
   } class_word_type;

   typedef struct packed {
      logic signed [SCORE_W-1:0] score;
      logic        [LABEL_W-1:0] label;
      logic                      active;
   } cand_type;

   typedef struct packed {
      logic en_diff;
      logic en_square;
      logic en_penalty;
      logic en_score;
   } lane_ctl_type;

   // depth of the registered compare tree, at least one level
   function automatic int tree_levels(input int n);
      int lv;
      lv = 1;
      for (int k = 0; k < 8; k++) begin
         if ((1 << lv) < n) begin
            lv = lv + 1;
         end
      end
      return lv;
   endfunction

endpackage

// File: src/gaussian_max_likelihood_pixel_classifier_top.sv
`timescale 1ns / 1ps
// Gaussian max-likelihood pixel classifier. Takes one pixel word per clock while
// the output is not stalled and returns one result word per pixel, in order. The
// compare tree has L = max(1, ceil(log2(MAX_CLASSES))) registered levels. Each
// class has its own lane (difference, square, multiply by inv2var, subtract from
// lognorm, one register each), fed by a pixel input register and followed by a
// registered pairwise compare tree and an output register; every stage holds one
// word, so a stall back-pressures stage by stage without losing data. Class
// registers must be written only while no pixel is in flight.
module gaussian_max_likelihood_pixel_classifier_top
   import gmlc_pkg::*;
#(
   parameter int MAX_CLASSES = 7
) (
   input  logic                clock,
   input  logic                reset,

   input  logic                req_valid,
   output logic                req_ready,
   input  logic [PIXEL_W-1:0]  req_pixel,

   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [LABEL_W-1:0]  rsp_class_label,
   output logic                rsp_no_class,

   input  logic                csr_write_enable,
   input  logic [INDEX_W-1:0]  csr_index,
   input  logic [WORD_W-1:0]   csr_wdata
);

   localparam int TREE_LEVELS = tree_levels(MAX_CLASSES);
   localparam int ST_PIX      = 0;
   localparam int ST_DIFF     = 1;
   localparam int ST_SQUARE   = 2;
   localparam int ST_PENALTY  = 3;
   localparam int ST_SCORE    = 4;
   localparam int ST_TREE     = 5;
   localparam int NST         = ST_TREE + TREE_LEVELS + 1;
   localparam int ST_OUT      = NST - 1;

   logic [COUNT_W-1:0]        class_count;
   class_word_type            class_word [MAX_CLASSES];
   logic signed [SCORE_W-1:0] score [MAX_CLASSES];
   logic [LABEL_W-1:0]        winner_label;
   lane_ctl_type              lane_ctl;

   logic [NST-1:0]     valid_ff;
   logic [NST-1:0]     valid_in;
   logic [NST-1:0]     en;
   logic [PIXEL_W-1:0] pixel_ff;
   logic [LABEL_W-1:0] label_ff;
   logic               no_class_ff;

   // a stage loads when it is empty or its word moves on
   always_comb begin
      en[ST_OUT] = !valid_ff[ST_OUT] || rsp_ready;
      for (int k = NST - 2; k >= 0; k--) begin
         en[k] = !valid_ff[k] || en[k+1];
      end
      valid_in = {valid_ff[NST-2:0], req_valid};
      lane_ctl = '{en_diff:    en[ST_DIFF],
                   en_square:  en[ST_SQUARE],
                   en_penalty: en[ST_PENALTY],
                   en_score:   en[ST_SCORE]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < NST; k++) begin
            if (en[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[ST_PIX]) begin
         pixel_ff <= req_pixel;
      end
      if (en[ST_OUT]) begin
         label_ff    <= winner_label;
         no_class_ff <= (class_count == '0);
      end
   end

   gmlc_csr #(
      .MAX_CLASSES (MAX_CLASSES)
   ) u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .class_count      (class_count),
      .class_word       (class_word)
   );

   for (genvar i = 0; i < MAX_CLASSES; i++) begin : g_lane
      gmlc_lane u_lane (
         .clock (clock),
         .pixel (pixel_ff),
         .word  (class_word[i]),
         .ctl   (lane_ctl),
         .score (score[i])
      );
   end

   gmlc_argmax #(
      .MAX_CLASSES (MAX_CLASSES)
   ) u_argmax (
      .clock        (clock),
      .score        (score),
      .class_word   (class_word),
      .class_count  (class_count),
      .en_tree      (en[ST_TREE +: TREE_LEVELS]),
      .winner_label (winner_label)
   );

   assign req_ready       = en[ST_PIX];
   assign rsp_valid       = valid_ff[ST_OUT];
   assign rsp_class_label = label_ff;
   assign rsp_no_class    = no_class_ff;

endmodule

// File: src/gmlc_csr.sv
`timescale 1ns / 1ps
module gmlc_csr
   import gmlc_pkg::*;
#(
   parameter int MAX_CLASSES = 7
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [INDEX_W-1:0]    csr_index,
   input  logic [WORD_W-1:0]     csr_wdata,
   output logic [COUNT_W-1:0]    class_count,
   output class_word_type        class_word [MAX_CLASSES]
);

   logic [COUNT_W-1:0] count_ff;
   class_word_type     word_ff [MAX_CLASSES];

   // words for classes at or above MAX_CLASSES are never scored, so not kept
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         for (int i = 0; i < MAX_CLASSES; i++) begin
            word_ff[i] <= '0;
         end
      end else if (csr_write_enable) begin
         if (csr_index == REG_COUNT) begin
            count_ff <= csr_wdata[COUNT_W-1:0];
         end
         for (int i = 0; i < MAX_CLASSES; i++) begin
            if (csr_index == INDEX_W'(int'(REG_CLASS0) + i)) begin
               word_ff[i] <= class_word_type'(csr_wdata);
            end
         end
      end
   end

   assign class_count = count_ff;
   assign class_word  = word_ff;

endmodule

// File: src/gmlc_lane.sv
`timescale 1ns / 1ps
module gmlc_lane
   import gmlc_pkg::*;
(
   input  logic                      clock,
   input  logic [PIXEL_W-1:0]        pixel,
   input  class_word_type            word,
   input  lane_ctl_type              ctl,
   output logic signed [SCORE_W-1:0] score
);

   logic signed [DIFF_W-1:0]  diff;
   logic signed [DIFF_W-1:0]  diff_neg;
   logic [ABS_W-1:0]          absd_in;
   logic [ABS_W-1:0]          absd_ff;
   logic [SQ_W-1:0]           sq_in;
   logic [SQ_W-1:0]           sq_ff;
   logic [PEN_W-1:0]          pen_in;
   logic [PEN_W-1:0]          pen_ff;
   logic signed [SCORE_W-1:0] lognorm_al;
   logic signed [SCORE_W-1:0] score_in;
   logic signed [SCORE_W-1:0] score_ff;

   always_comb begin
      diff     = $signed({2'b00, pixel, 8'h00}) - $signed({2'b00, word.mean});
      diff_neg = -diff;
      absd_in  = diff[DIFF_W-1] ? diff_neg[ABS_W-1:0] : diff[ABS_W-1:0];
      sq_in    = SQ_W'(absd_ff) * SQ_W'(absd_ff);
      pen_in   = PEN_W'(sq_ff) * PEN_W'(word.inv2var);
      lognorm_al = $signed({{(SCORE_W - LOGNORM_W - LOG_SHIFT){word.lognorm[LOGNORM_W-1]}},
                            word.lognorm, {LOG_SHIFT{1'b0}}});
      score_in = lognorm_al - $signed({2'b00, pen_ff});
   end

   always_ff @(posedge clock) begin
      if (ctl.en_diff) begin
         absd_ff <= absd_in;
      end
      if (ctl.en_square) begin
         sq_ff <= sq_in;
      end
      if (ctl.en_penalty) begin
         pen_ff <= pen_in;
      end
      if (ctl.en_score) begin
         score_ff <= score_in;
      end
   end

   assign score = score_ff;

endmodule

// File: src/gmlc_argmax.sv
`timescale 1ns / 1ps
module gmlc_argmax
   import gmlc_pkg::*;
#(
   parameter  int MAX_CLASSES = 7,
   localparam int TREE_LEVELS = tree_levels(MAX_CLASSES)
) (
   input  logic                      clock,
   input  logic signed [SCORE_W-1:0] score [MAX_CLASSES],
   input  class_word_type            class_word [MAX_CLASSES],
   input  logic [COUNT_W-1:0]        class_count,
   input  logic [TREE_LEVELS-1:0]    en_tree,
   output logic [LABEL_W-1:0]        winner_label
);

   localparam int NPAD = 1 << TREE_LEVELS;

   cand_type leaf    [NPAD];
   cand_type all_c   [1:2*NPAD-1];
   cand_type node_in [1:NPAD-1];
   cand_type node_ff [1:NPAD-1];
   logic     node_en [1:NPAD-1];

   // only classes below class_count take part; others carry label 0
   for (genvar i = 0; i < NPAD; i++) begin : g_leaf
      if (i < MAX_CLASSES) begin : g_used
         logic act;
         assign act = (COUNT_W'(i) < class_count);
         assign leaf[i] = '{score:  score[i],
                            label:  act ? class_word[i].label : '0,
                            active: act};
      end else begin : g_pad
         assign leaf[i] = '0;
      end
   end

   always_comb begin
      for (int j = 1; j < NPAD; j++) begin
         all_c[j] = node_ff[j];
      end
      for (int j = 0; j < NPAD; j++) begin
         all_c[NPAD + j] = leaf[j];
      end
      // right child wins if active and the left is inactive or scores strictly lower: ties stay low
      for (int j = 1; j < NPAD; j++) begin
         if (all_c[2*j+1].active &&
             (!all_c[2*j].active || (all_c[2*j+1].score > all_c[2*j].score))) begin
            node_in[j] = all_c[2*j+1];
         end else begin
            node_in[j] = all_c[2*j];
         end
      end
      for (int d = 0; d < TREE_LEVELS; d++) begin
         for (int j = (1 << d); j < (2 << d); j++) begin
            node_en[j] = en_tree[TREE_LEVELS-1-d];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 1; j < NPAD; j++) begin
         if (node_en[j]) begin
            node_ff[j] <= node_in[j];
         end
      end
   end

   assign winner_label = node_ff[1].label;

endmodule
